// File: rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants of the row smoothness indicator.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  localparam int unsigned SumW   = 64;
  localparam int unsigned FloorW = 41;
  localparam int unsigned AlphaW = 17;
  localparam int unsigned QDepth = 2;

  // register index of the divisor floor
  localparam logic RegFloor = 1'b0;

  // finished row sums handed from the accumulator to the divider
  typedef struct packed {
    logic [SumW-1:0] ssum;
    logic [SumW-1:0] msum;
  } rsi_row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } rsi_state_e;

endpackage

`default_nettype wire

// File: rtl/row_smoothness_indicator.sv
// ----------------------------------------------------------------------------
// row_smoothness_indicator
// Saturating row sums of a*(uj-ui) and |a*(uj-ui)|, alpha at each row end.
// ----------------------------------------------------------------------------
// Throughput: one matrix entry per cycle while full is low; the divider
//   works out each row in its one-bit-a-cycle restoring loop.
// A two-row queue lets rows shorter than the divide stream on; full rises
//   only when that queue is full at a row end.
// Reset: asynchronous, clears sums, queue and output; floor returns to 1e-6.
// ----------------------------------------------------------------------------
`default_nettype none

module row_smoothness_indicator #(
  parameter int unsigned FRAC_BITS  = 20,
  parameter int unsigned ALPHA_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // entry channel
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [31:0] coeff_i,
  input  wire logic signed [31:0] neighbour_value_i,
  input  wire logic signed [31:0] centre_value_i,
  input  wire logic               skip_entry_i,
  input  wire logic               last_entry_i,
  // result channel
  output logic                    empty,
  input  wire logic               pop,
  output logic [16:0]             alpha_o,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);
  import rsi_pkg::*;

  // 1e-6 in product scale, rounded
  localparam logic [63:0] FloorFull =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;
  localparam logic [FloorW-1:0] FloorReset = FloorFull[FloorW-1:0];

  logic [FloorW-1:0] floor_q;
  logic              row_valid, row_full, q_empty, q_pop;
  rsi_row_t          row, q_data;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FloorReset;
    end else if (psel && penable && pwrite && pready && (paddr[3] == RegFloor)) begin
      floor_q <= pwdata[FloorW-1:0];
    end
  end

  assign prdata = (paddr[3] == RegFloor) ? 64'(floor_q) : 64'd0;

  rsi_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_o            (full),
    .coeff_i           (coeff_i),
    .neighbour_value_i (neighbour_value_i),
    .centre_value_i    (centre_value_i),
    .skip_entry_i      (skip_entry_i),
    .last_entry_i      (last_entry_i),
    .row_valid_o       (row_valid),
    .row_o             (row),
    .row_full_i        (row_full)
  );

  rsi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (row_valid),
    .wdata_i (row),
    .full_o  (row_full),
    .rd_i    (q_pop),
    .rdata_o (q_data),
    .empty_o (q_empty)
  );

  rsi_back #(
    .ALPHA_BITS (ALPHA_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .floor_i   (floor_q),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .alpha_o   (alpha_o)
  );

endmodule

`default_nettype wire

// File: rtl/rsi_front.sv
// ----------------------------------------------------------------------------
// rsi_front
// Entry pipeline: difference and magnitudes, product, sign, saturating sums.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic signed [31:0] coeff_i,
  input  wire logic signed [31:0] neighbour_value_i,
  input  wire logic signed [31:0] centre_value_i,
  input  wire logic              skip_entry_i,
  input  wire logic              last_entry_i,
  output logic                   row_valid_o,
  output rsi_pkg::rsi_row_t      row_o,
  input  wire logic              row_full_i
);
  import rsi_pkg::*;

  localparam logic [SumW-1:0] SMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0] SMin = {1'b1, {(SumW-1){1'b0}}};

  logic            adv;
  logic            accept;

  // stage 1
  logic [32:0]     diff;
  logic [32:0]     diff_neg;
  logic [32:0]     coeff_neg;
  logic [31:0]     a_abs_d, a_abs_q;
  logic [31:0]     d_abs_d, d_abs_q;
  logic            neg1_q, last1_q, v1_q;
  // stage 2
  logic [63:0]     mag_d, mag2_q;
  logic            neg2_q, last2_q, v2_q;
  // stage 3
  logic [63:0]     p3_q, m3_q;
  logic            last3_q, v3_q;
  // sums
  logic [SumW-1:0] ssum_q, ssum_d, ssum_new;
  logic [SumW-1:0] msum_q, msum_d, msum_new;
  logic [SumW:0]   s_add, m_add;

  assign full_o = v3_q && last3_q && row_full_i;
  assign adv    = !full_o;
  assign accept = push_i && !full_o;

  assign diff      = {neighbour_value_i[31], neighbour_value_i}
                   - {centre_value_i[31], centre_value_i};
  assign diff_neg  = -diff;
  assign coeff_neg = -{coeff_i[31], coeff_i};

  always_comb begin
    d_abs_d = diff[32] ? diff_neg[31:0] : diff[31:0];
    a_abs_d = coeff_i[31] ? coeff_neg[31:0] : coeff_i;
    // a skipped entry adds zero to both sums
    if (skip_entry_i) begin
      a_abs_d = '0;
    end
  end

  assign mag_d = a_abs_q * d_abs_q;

  always_comb begin
    s_add = {ssum_q[SumW-1], ssum_q} + {p3_q[63], p3_q};
    m_add = {1'b0, msum_q} + {1'b0, m3_q};
    if (s_add[SumW] != s_add[SumW-1]) begin
      ssum_new = s_add[SumW] ? SMin : SMax;
    end else begin
      ssum_new = s_add[SumW-1:0];
    end
    msum_new = m_add[SumW] ? {SumW{1'b1}} : m_add[SumW-1:0];
  end

  always_comb begin
    ssum_d = ssum_q;
    msum_d = msum_q;
    if (adv && v3_q) begin
      if (last3_q) begin
        ssum_d = '0;
        msum_d = '0;
      end else begin
        ssum_d = ssum_new;
        msum_d = msum_new;
      end
    end
  end

  assign row_valid_o = adv && v3_q && last3_q;
  assign row_o.ssum  = ssum_new;
  assign row_o.msum  = msum_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      last1_q <= 1'b0;
      last2_q <= 1'b0;
      last3_q <= 1'b0;
      ssum_q  <= '0;
      msum_q  <= '0;
    end else begin
      ssum_q <= ssum_d;
      msum_q <= msum_d;
      if (adv) begin
        v1_q    <= accept;
        v2_q    <= v1_q;
        v3_q    <= v2_q;
        last1_q <= accept && last_entry_i;
        last2_q <= last1_q;
        last3_q <= last2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_abs_q <= a_abs_d;
      d_abs_q <= d_abs_d;
      neg1_q  <= coeff_i[31] ^ diff[32];
      mag2_q  <= mag_d;
      neg2_q  <= neg1_q;
      p3_q    <= neg2_q ? -mag2_q : mag2_q;
      m3_q    <= mag2_q;
    end
  end

  // the signed sum never exceeds the magnitude sum in size
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ssum_q[SumW-1] ? (msum_q >= -ssum_q) : (msum_q >= ssum_q)))
    else $error("signed sum larger than magnitude sum");

endmodule

`default_nettype wire

// File: rtl/rsi_fifo.sv
// ----------------------------------------------------------------------------
// rsi_fifo
// Short queue of finished row sums between accumulator and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         wr_i,
  input  rsi_pkg::rsi_row_t wdata_i,
  output logic              full_o,
  input  wire logic         rd_i,
  output rsi_pkg::rsi_row_t rdata_o,
  output logic              empty_o
);
  import rsi_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  rsi_row_t          mem_q [QDepth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rsi_back.sv
// ----------------------------------------------------------------------------
// rsi_back
// Row-end divider: |sum| / max(magnitude, floor), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_back #(
  parameter int unsigned ALPHA_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [rsi_pkg::FloorW-1:0] floor_i,
  input  wire logic                       q_empty_i,
  input  rsi_pkg::rsi_row_t               q_data_i,
  output logic                            q_pop_o,
  output logic                            empty_o,
  input  wire logic                       pop_i,
  output logic [rsi_pkg::AlphaW-1:0]      alpha_o
);
  import rsi_pkg::*;

  localparam int unsigned QW   = ALPHA_BITS + 1;
  localparam int unsigned CntW = $clog2(ALPHA_BITS);
  localparam logic [QW-1:0] One = {1'b1, {ALPHA_BITS{1'b0}}};

  rsi_state_e        state_q, state_d;
  logic [SumW-1:0]   num_q, den_q, rem_q;
  logic [SumW-1:0]   s_neg, floor_eff, den_load;
  logic [QW-1:0]     quo_q;
  logic [CntW-1:0]   cnt_q;
  logic [SumW:0]     rem_sh, rem_sub;
  logic              take_bit;
  logic              out_free;
  logic              load_out;
  logic              out_valid_q;
  logic [AlphaW-1:0] alpha_q;

  assign out_free = !out_valid_q || pop_i;

  assign s_neg     = -q_data_i.ssum;
  assign floor_eff = (floor_i == '0) ? SumW'(1) : SumW'(floor_i);
  assign den_load  = (q_data_i.msum > floor_eff) ? q_data_i.msum : floor_eff;

  assign rem_sh   = {rem_q, 1'b0};
  assign rem_sub  = rem_sh - {1'b0, den_q};
  assign take_bit = (rem_sh >= {1'b0, den_q});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (!q_empty_i) state_d = ST_CHECK;
      ST_CHECK:  state_d = (num_q >= den_q) ? ST_FINISH : ST_DIV;
      ST_DIV:    if (cnt_q == CntW'(ALPHA_BITS - 1)) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE:   q_pop_o  = !q_empty_i;
      ST_FINISH: load_out = out_free;
      default: begin
        q_pop_o  = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        num_q <= q_data_i.ssum[SumW-1] ? s_neg : q_data_i.ssum;
        den_q <= den_load;
      end
      ST_CHECK: begin
        rem_q <= num_q;
        cnt_q <= '0;
        quo_q <= (num_q >= den_q) ? One : '0;
      end
      ST_DIV: begin
        rem_q <= take_bit ? rem_sub[SumW-1:0] : rem_sh[SumW-1:0];
        quo_q <= {quo_q[QW-2:0], take_bit};
        cnt_q <= cnt_q + 1'b1;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      alpha_q <= AlphaW'(quo_q);
    end
  end

  assign empty_o = !out_valid_q;
  assign alpha_o = alpha_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < den_q))
    else $error("remainder not below divisor");

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> (quo_q <= One))
    else $error("quotient above one");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> (den_q != '0))
    else $error("zero divisor");

  a_pop_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == ST_CHECK))
    else $error("row taken from queue without starting a divide");

endmodule

`default_nettype wire
